FILE: rtl/lfps_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and tables of the line-follower steering block.
package lfps_pkg;

  localparam int unsigned SensorCount  = 8;
  localparam int unsigned GainFracBits = 8;
  localparam int unsigned RecipShift   = 14;

  localparam int unsigned SensorW = 8;
  localparam int unsigned WeightW = 8;
  localparam int unsigned SumW    = 11;
  localparam int unsigned CntW    = 4;
  localparam int unsigned RecipW  = 15;
  localparam int unsigned QuotW   = SumW + RecipW;
  localparam int unsigned ErrW    = 8;
  localparam int unsigned DiffW   = ErrW + 1;
  localparam int unsigned GainW   = 16;
  localparam int unsigned ProdW   = GainW + DiffW;
  localparam int unsigned TermW   = ProdW - GainFracBits;
  localparam int unsigned IntW    = 32;
  localparam int unsigned PidW    = IntW + 2;
  localparam int unsigned DrvW    = PidW + 1;
  localparam int unsigned DriveW  = 10;

  localparam logic [DriveW-1:0] DriveLimit     = 10'd999;
  localparam logic [DriveW-1:0] BaseSpeedReset = 10'd120;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CfgLineWeights = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGainP       = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGainI       = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgGainD       = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBaseSpeed   = 3'd4;

  typedef struct packed {
    logic load_in;
    logic calc_sum;
    logic calc_div;
    logic calc_err;
    logic calc_p;
    logic calc_i;
    logic calc_d;
    logic upd_int;
    logic calc_pid;
    logic load_out;
  } lfps_cmd_t;

  // Rounded-up reciprocal of the seen-sensor count, scaled by 2^RecipShift.
  function automatic logic [RecipW-1:0] recip_f(input logic [CntW-1:0] cnt);
    logic [RecipW-1:0] r;
    case (cnt)
      4'd1:    r = 15'd16384;
      4'd2:    r = 15'd8192;
      4'd3:    r = 15'd5462;
      4'd4:    r = 15'd4096;
      4'd5:    r = 15'd3277;
      4'd6:    r = 15'd2731;
      4'd7:    r = 15'd2341;
      4'd8:    r = 15'd2048;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/lfps_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sensor word and the drive word.
interface lfps_in_if;
  logic                          valid;
  logic                          ready;
  logic [lfps_pkg::SensorW-1:0]  sensor_bits;

  modport source (output valid, output sensor_bits, input ready);
  modport sink   (input valid, input sensor_bits, output ready);
endinterface

interface lfps_out_if;
  logic                          valid;
  logic                          ready;
  logic [lfps_pkg::DriveW-1:0]   left_drive;
  logic [lfps_pkg::DriveW-1:0]   right_drive;
  logic signed [lfps_pkg::ErrW-1:0] line_error;
  logic                          line_lost;

  modport source (output valid, output left_drive, output right_drive, output line_error,
                  output line_lost, input ready);
  modport sink   (input valid, input left_drive, input right_drive, input line_error,
                  input line_lost, output ready);
endinterface

FILE: rtl/line_follow_pid_steering_top.sv
`timescale 1ns / 1ps
// Top level of the line-follower steering block: sequencer plus datapath.
//
// One sensor word enters on in_i per control tick; a 0 bit marks a sensor over the line.
// The block forms the weighted centroid of the seen sensors, runs it through a PID with
// signed Q8.8 gains and returns one word on out_o: left and right wheel drive clamped to
// 0..999, the line error and a line-lost flag.
// Settings are written through cfg_we_i, cfg_idx_i and cfg_data_i by the user only while
// the block is idle, which the block does not enforce: index 0 the packed weights, 1 to 3
// the P, I and D gains, 4 the base speed.
// Each tick steps through centroid sum, reciprocal divide, error, the three PID terms on
// one shared multiplier, integral update, PID sum and output clamp. A new word is taken
// only once the sequencer is back in idle after the previous result has been loaded.
// The output register holds the finished word; the next sensor word is accepted while it
// waits. If the receiver still stalls when the following result is ready, the sequencer
// holds in its last step until the output register is free.
// Reset clears the integral, the previous error, the gains and weights, sets the base
// speed to 120 and leaves the block idle with no result pending.
module line_follow_pid_steering_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lfps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lfps_pkg::CfgDataW-1:0] cfg_data_i,
  lfps_in_if.sink                       in_i,
  lfps_out_if.source                    out_o
);

  lfps_pkg::lfps_cmd_t cmd;

  lfps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  lfps_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .sensor_bits_i (in_i.sensor_bits),
    .left_drive_o  (out_o.left_drive),
    .right_drive_o (out_o.right_drive),
    .line_error_o  (out_o.line_error),
    .line_lost_o   (out_o.line_lost)
  );

endmodule

FILE: rtl/lfps_ctrl.sv
`timescale 1ns / 1ps
// Sequencer that steps the datapath through one control tick and owns the handshakes.
module lfps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lfps_pkg::lfps_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SUM  = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_ERR  = 4'd3;
  localparam logic [3:0] S_P    = 4'd4;
  localparam logic [3:0] S_I    = 4'd5;
  localparam logic [3:0] S_D    = 4'd6;
  localparam logic [3:0] S_INT  = 4'd7;
  localparam logic [3:0] S_PID  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.calc_sum = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.calc_div = 1'b1;
        state_d        = S_ERR;
      end
      S_ERR: begin
        cmd_o.calc_err = 1'b1;
        state_d        = S_P;
      end
      S_P: begin
        cmd_o.calc_p = 1'b1;
        state_d      = S_I;
      end
      S_I: begin
        cmd_o.calc_i = 1'b1;
        state_d      = S_D;
      end
      S_D: begin
        cmd_o.calc_d = 1'b1;
        state_d      = S_INT;
      end
      S_INT: begin
        cmd_o.upd_int = 1'b1;
        state_d       = S_PID;
      end
      S_PID: begin
        cmd_o.calc_pid = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/lfps_dp.sv
`timescale 1ns / 1ps
// Datapath: settings registers, centroid, reciprocal divide, shared PID multiplier and clamps.
module lfps_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lfps_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [lfps_pkg::CfgDataW-1:0]        cfg_data_i,
  input  lfps_pkg::lfps_cmd_t                  cmd_i,
  input  logic [lfps_pkg::SensorW-1:0]         sensor_bits_i,
  output logic [lfps_pkg::DriveW-1:0]          left_drive_o,
  output logic [lfps_pkg::DriveW-1:0]          right_drive_o,
  output logic signed [lfps_pkg::ErrW-1:0]     line_error_o,
  output logic                                 line_lost_o
);

  localparam logic [lfps_pkg::ProdW-1:0] GainBias = lfps_pkg::ProdW'((1 << lfps_pkg::GainFracBits) - 1);
  localparam logic signed [lfps_pkg::IntW-1:0] IntMax = {1'b0, {(lfps_pkg::IntW-1){1'b1}}};
  localparam logic signed [lfps_pkg::IntW-1:0] IntMin = {1'b1, {(lfps_pkg::IntW-1){1'b0}}};

  logic [lfps_pkg::CfgDataW-1:0]       weights_q;
  logic signed [lfps_pkg::GainW-1:0]   gain_p_q, gain_i_q, gain_d_q;
  logic [lfps_pkg::DriveW-1:0]         base_q;

  logic signed [lfps_pkg::IntW-1:0]    integral_q;
  logic signed [lfps_pkg::ErrW-1:0]    prev_q;

  logic [lfps_pkg::SensorW-1:0]        bits_q;
  logic signed [lfps_pkg::SumW-1:0]    sum_q, sum_d;
  logic [lfps_pkg::CntW-1:0]           cnt_q, cnt_d;
  logic [lfps_pkg::ErrW-1:0]           qmag_q;
  logic                                neg_q, lost_q;
  logic signed [lfps_pkg::ErrW-1:0]    err_q, err_d;
  logic signed [lfps_pkg::DiffW-1:0]   diff_q, diff_d;
  logic signed [lfps_pkg::TermW-1:0]   p_q, ti_q, d_q, term_w;
  logic signed [lfps_pkg::PidW-1:0]    pid_q, pid_d;

  logic [lfps_pkg::SumW-1:0]           mag_w;
  logic [lfps_pkg::QuotW-1:0]          quot_w;
  logic signed [lfps_pkg::GainW-1:0]   mul_a;
  logic signed [lfps_pkg::DiffW-1:0]   mul_b;
  logic signed [lfps_pkg::ProdW-1:0]   prod_w;
  logic [lfps_pkg::ProdW-1:0]          biased_w;
  logic signed [lfps_pkg::IntW:0]      acc_w;
  logic signed [lfps_pkg::IntW-1:0]    integral_d;
  logic signed [lfps_pkg::DrvW-1:0]    left_w, right_w, base_w;

  logic [lfps_pkg::DriveW-1:0]         left_q, right_q;
  logic signed [lfps_pkg::ErrW-1:0]    line_error_q;
  logic                                line_lost_q;

  function automatic logic [lfps_pkg::DriveW-1:0] clamp_drive(
    input logic signed [lfps_pkg::DrvW-1:0] v
  );
    logic [lfps_pkg::DriveW-1:0] r;
    if (v[lfps_pkg::DrvW-1]) begin
      r = '0;
    end else if ($unsigned(v) > lfps_pkg::DrvW'(lfps_pkg::DriveLimit)) begin
      r = lfps_pkg::DriveLimit;
    end else begin
      r = v[lfps_pkg::DriveW-1:0];
    end
    return r;
  endfunction

  // Sum and count of the weights of sensors that see the line.
  always_comb begin
    sum_d = '0;
    cnt_d = '0;
    for (int i = 0; i < lfps_pkg::SensorCount; i++) begin
      if (!bits_q[i]) begin
        sum_d = sum_d + {{(lfps_pkg::SumW-lfps_pkg::WeightW){weights_q[8*i+7]}},
                         weights_q[8*i +: lfps_pkg::WeightW]};
        cnt_d = cnt_d + 4'd1;
      end
    end
  end

  // Magnitude divided by the count through a reciprocal multiply.
  assign mag_w  = sum_q[lfps_pkg::SumW-1] ? lfps_pkg::SumW'(-sum_q) : sum_q;
  assign quot_w = lfps_pkg::QuotW'(mag_w) * lfps_pkg::QuotW'(lfps_pkg::recip_f(cnt_q));

  assign err_d  = lost_q ? '0 : (neg_q ? lfps_pkg::ErrW'(8'd0 - qmag_q) : qmag_q);
  assign diff_d = lfps_pkg::DiffW'(err_d) - lfps_pkg::DiffW'(prev_q);

  // One multiplier serves all three terms; each is truncated toward zero.
  assign mul_a    = cmd_i.calc_p ? gain_p_q : (cmd_i.calc_i ? gain_i_q : gain_d_q);
  assign mul_b    = cmd_i.calc_d ? diff_q : lfps_pkg::DiffW'(err_q);
  assign prod_w   = lfps_pkg::ProdW'(mul_a) * lfps_pkg::ProdW'(mul_b);
  assign biased_w = prod_w + (prod_w[lfps_pkg::ProdW-1] ? GainBias : '0);
  assign term_w   = biased_w[lfps_pkg::ProdW-1:lfps_pkg::GainFracBits];

  assign acc_w = (lfps_pkg::IntW+1)'(integral_q) + (lfps_pkg::IntW+1)'(ti_q);
  always_comb begin
    if (acc_w[lfps_pkg::IntW] != acc_w[lfps_pkg::IntW-1]) begin
      integral_d = acc_w[lfps_pkg::IntW] ? IntMin : IntMax;
    end else begin
      integral_d = acc_w[lfps_pkg::IntW-1:0];
    end
  end

  assign pid_d   = lfps_pkg::PidW'(p_q) + lfps_pkg::PidW'(integral_q) + lfps_pkg::PidW'(d_q);
  assign base_w  = lfps_pkg::DrvW'({1'b0, base_q});
  assign left_w  = base_w + lfps_pkg::DrvW'(pid_q);
  assign right_w = base_w - lfps_pkg::DrvW'(pid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q  <= '0;
      gain_p_q   <= '0;
      gain_i_q   <= '0;
      gain_d_q   <= '0;
      base_q     <= lfps_pkg::BaseSpeedReset;
      integral_q <= '0;
      prev_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lfps_pkg::CfgLineWeights: weights_q <= cfg_data_i;
          lfps_pkg::CfgGainP:       gain_p_q  <= cfg_data_i[lfps_pkg::GainW-1:0];
          lfps_pkg::CfgGainI:       gain_i_q  <= cfg_data_i[lfps_pkg::GainW-1:0];
          lfps_pkg::CfgGainD:       gain_d_q  <= cfg_data_i[lfps_pkg::GainW-1:0];
          lfps_pkg::CfgBaseSpeed:   base_q    <= cfg_data_i[lfps_pkg::DriveW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.upd_int) begin
        integral_q <= integral_d;
        prev_q     <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      bits_q <= sensor_bits_i;
    end
    if (cmd_i.calc_sum) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
    if (cmd_i.calc_div) begin
      qmag_q <= quot_w[lfps_pkg::RecipShift +: lfps_pkg::ErrW];
      neg_q  <= sum_q[lfps_pkg::SumW-1];
      lost_q <= (cnt_q == '0);
    end
    if (cmd_i.calc_err) begin
      err_q  <= err_d;
      diff_q <= diff_d;
    end
    if (cmd_i.calc_p) begin
      p_q <= term_w;
    end
    if (cmd_i.calc_i) begin
      ti_q <= term_w;
    end
    if (cmd_i.calc_d) begin
      d_q <= term_w;
    end
    if (cmd_i.calc_pid) begin
      pid_q <= pid_d;
    end
    if (cmd_i.load_out) begin
      left_q       <= clamp_drive(left_w);
      right_q      <= clamp_drive(right_w);
      line_error_q <= err_q;
      line_lost_q  <= lost_q;
    end
  end

  assign left_drive_o  = left_q;
  assign right_drive_o = right_q;
  assign line_error_o  = line_error_q;
  assign line_lost_o   = line_lost_q;

endmodule
